// File: hdl/mbd_pkg.sv
// Shared types, register indexes and lane helpers for the mip level box downsampler.
package mbd_pkg;

    localparam int unsigned CHANNELS   = 4;
    localparam int unsigned CHAN_BITS  = 8;
    localparam int unsigned LANE_BITS  = CHAN_BITS + 1;
    localparam int unsigned SUM_BITS   = CHAN_BITS + 2;
    localparam int unsigned PIX_BITS   = CHANNELS * CHAN_BITS;
    localparam int unsigned PAIR_BITS  = CHANNELS * LANE_BITS;
    localparam int unsigned SIZE_BITS  = 13;
    localparam int unsigned COUNT_BITS = 3;
    localparam int unsigned CFG_BITS   = 13;
    localparam int unsigned INDEX_BITS = 2;
    localparam int unsigned COORD_BITS = 11;

    typedef logic [PIX_BITS-1:0]   t_pix;
    typedef logic [PAIR_BITS-1:0]  t_pair;
    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_SOURCE_WIDTH  = 2'd0,
        REG_SOURCE_HEIGHT = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    // Lane-wise sum of two pixels: four 9-bit sums packed without gaps.
    function automatic t_pair pair_of_pixels(input t_pix a, input t_pix b);
        t_pair p;
        p = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            p[k*LANE_BITS +: LANE_BITS] = {1'b0, a[k*CHAN_BITS +: CHAN_BITS]}
                                        + {1'b0, b[k*CHAN_BITS +: CHAN_BITS]};
        end
        return p;
    endfunction

endpackage

// File: hdl/mipmap_box_downsampler.sv
// Top level of the mip level 2x2 box downsampler with its two line memories.
//
// Usage: program source_width, source_height and channel_count through the cfg
// channel while the block is idle; any transaction there to an index other
// than REG_UNUSED restarts the level. Then stream the source level in raster
// order on s_axis, one pixel per transaction (tdata: chan0..chan3, lowest byte
// first). Each finished 2x2 block leaves on m_axis with tdata holding chan0..chan3,
// out_col, out_row and tlast marking the last pixel of the next level.
// Throughput: one source pixel per cycle while m_axis does not stall. A result
// passes the synchronous line-memory read stage and then the output register
// after the transaction of the source pixel that completes its block. Two line
// memories of (MAX_WIDTH+1)/2 entries hold horizontal pair sums of the last
// even row and of row 0; each takes one write and one read per cycle.
// Reset clears the counters, the sizes (1x1) and the channel count (4); the
// memories are not cleared and need no clearing pass, since every entry is
// written within a level before it is read. When the receiver stalls, the
// output register and the read stage hold, and s_axis_tready drops until the
// read stage can move on.
module mipmap_box_downsampler
    import mbd_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]   i_cfg_data,
    // Source pixels.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // chan0_in, chan1_in, chan2_in, chan3_in
    // Result pixels.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [55:0]           m_axis_tdata,  // chan0..chan3_out, out_col, out_row, pad
    output logic                  m_axis_tlast   // level_done
);

    localparam int unsigned CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RW         = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned LINE_SLOTS = (MAX_WIDTH + 1) / 2;
    localparam int unsigned IW         = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;

    // Configuration state, sizes kept as last index (size minus one).
    logic [CW-1:0]         r_w_last;
    logic [RW-1:0]         r_h_last;
    logic [COUNT_BITS-1:0] r_chan_count;

    // Stream position and pixel holding registers.
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pix          r_row_first;
    t_pix          r_pending;

    // Read stage.
    logic          r_s1_valid;
    t_pair         r_s1_pair;
    logic          r_s1_top;
    logic          r_s1_self;
    t_coord        r_s1_col;
    t_coord        r_s1_row;
    logic          r_s1_done;
    t_pair         r_even_q;
    t_pair         r_top_q;

    // Output register.
    logic          r_out_valid;
    logic [55:0]   r_out_data;
    logic          r_out_last;

    t_pair         even_mem [LINE_SLOTS];
    t_pair         top_mem  [LINE_SLOTS];

    logic          cfg_fire;
    logic          in_fire;
    logic          out_free;
    t_pix          px;
    t_pix          first_px;
    logic          col_odd;
    logic          col_last;
    logic          row_odd;
    logic          row_zero;
    logic          row_last;
    logic          have_pair;
    t_pair         pair;
    logic [CW-1:0] col_half;
    logic [RW-1:0] row_half;
    logic [IW-1:0] idx;
    logic          emit;
    logic          wr_top;
    logic          wr_even;
    t_pair         other;
    logic [55:0]   n_out_data;
    logic [15:0]   cfg_wide;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;
    assign cfg_wide    = {{(16-CFG_BITS){1'b0}}, i_cfg_data};

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign px       = s_axis_tdata;
    assign col_odd  = r_col[0];
    assign col_last = (r_col == r_w_last);
    assign row_odd  = r_row[0];
    assign row_zero = (r_row == '0);
    assign row_last = (r_row == r_h_last);
    assign first_px = (r_col == '0) ? px : r_row_first;

    assign have_pair = col_odd || col_last;
    assign pair      = col_odd ? pair_of_pixels(r_pending, px) : pair_of_pixels(px, first_px);
    assign col_half  = r_col >> 1;
    assign row_half  = r_row >> 1;
    assign idx       = col_half[IW-1:0];

    assign emit    = have_pair && (row_odd || row_last);
    assign wr_top  = in_fire && have_pair && !row_odd && row_zero;
    assign wr_even = in_fire && have_pair && !row_odd && !row_last;

    // Line memories: written and read in the same stage, never the same entry
    // by one pixel, except the single-row case which bypasses the read.
    always_ff @(posedge i_clk) begin
        if (wr_even) begin
            even_mem[idx] <= pair;
        end
        if (wr_top) begin
            top_mem[idx] <= pair;
        end
        if (in_fire && emit) begin
            r_even_q <= even_mem[idx];
            r_top_q  <= top_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last     <= '0;
            r_h_last     <= '0;
            r_chan_count <= COUNT_BITS'(CHANNELS);
            r_col        <= '0;
            r_row        <= '0;
            r_row_first  <= '0;
            r_pending    <= '0;
        end else if (cfg_fire) begin
            case (t_reg_index'(i_cfg_index))
                REG_SOURCE_WIDTH: begin
                    if (cfg_wide == '0) begin
                        r_w_last <= '0;
                    end else if (cfg_wide > 16'(MAX_WIDTH)) begin
                        r_w_last <= CW'(MAX_WIDTH - 1);
                    end else begin
                        r_w_last <= CW'(cfg_wide - 16'd1);
                    end
                end
                REG_SOURCE_HEIGHT: begin
                    if (cfg_wide == '0) begin
                        r_h_last <= '0;
                    end else if (cfg_wide > 16'(MAX_HEIGHT)) begin
                        r_h_last <= RW'(MAX_HEIGHT - 1);
                    end else begin
                        r_h_last <= RW'(cfg_wide - 16'd1);
                    end
                end
                REG_CHANNEL_COUNT: begin
                    r_chan_count <= i_cfg_data[COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
            if (t_reg_index'(i_cfg_index) != REG_UNUSED) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else if (in_fire) begin
            if (!col_odd) begin
                r_pending <= px;
                if (r_col == '0) begin
                    r_row_first <= px;
                end
            end
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Read stage: the memory data lands next to the held pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= emit;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_s1_pair <= pair;
            r_s1_top  <= !row_odd;
            r_s1_self <= !row_odd && row_zero;
            r_s1_col  <= t_coord'(col_half);
            r_s1_row  <= t_coord'(row_half);
            r_s1_done <= (col_half == (r_w_last >> 1)) && (row_half == (r_h_last >> 1));
        end
    end

    assign other = r_s1_self ? r_s1_pair : (r_s1_top ? r_top_q : r_even_q);

    always_comb begin
        logic [SUM_BITS-1:0] s;
        n_out_data = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            s = {1'b0, r_s1_pair[k*LANE_BITS +: LANE_BITS]}
              + {1'b0, other[k*LANE_BITS +: LANE_BITS]};
            if (COUNT_BITS'(k) < r_chan_count) begin
                n_out_data[k*CHAN_BITS +: CHAN_BITS] = s[SUM_BITS-1:2];
            end
        end
        n_out_data[PIX_BITS +: COORD_BITS]              = r_s1_col;
        n_out_data[PIX_BITS + COORD_BITS +: COORD_BITS] = r_s1_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_data <= n_out_data;
            r_out_last <= r_s1_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
